// ===== rtl/lcrs_pkg.sv =====
// Shared types, codes and constants of the LED color ramp sequencer.
package lcrs_pkg;

    // Sizes and limits
    localparam int LED_COUNT_DEFAULT = 4;
    localparam int ADDR_W            = 4;
    localparam int DATA_W            = 32;
    localparam int QUEUE_DEPTH       = 3;

    // Register reset values
    localparam logic [7:0]  DIM_RESET  = 8'd8;
    localparam logic [7:0]  FULL_RESET = 8'd255;
    localparam logic [15:0] STEP_RESET = 16'd5;
    localparam logic [15:0] HOLD_RESET = 16'd150;

    // Ramp arithmetic: ten steps per ramp, divide by ten as multiply and shift
    localparam logic [3:0]  RAMP_STEPS  = 4'd10;
    localparam logic [12:0] DIV10_MUL   = 13'd6554;
    localparam int          DIV10_SHIFT = 16;

    // Register map, one word per register
    typedef enum logic [1:0] {
        REG_DIM  = 2'd0,
        REG_FULL = 2'd1,
        REG_STEP = 2'd2,
        REG_HOLD = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        COL_RED   = 2'd0,
        COL_GREEN = 2'd1,
        COL_BLUE  = 2'd2
    } color_t;

    typedef enum logic [2:0] {
        PH_WHITE_TO_DIM = 3'd0,
        PH_DIM_TO_FULL  = 3'd1,
        PH_HOLD         = 3'd2,
        PH_FULL_TO_DIM  = 3'd3,
        PH_DIM_TO_WHITE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]  dim_level;
        logic [7:0]  full_level;
        logic [15:0] step_ticks;
        logic [15:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic       fill_all;
        logic [1:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } frame_t;

    // Frames produced by one tick: cnt of 0, 1 or 2, first goes out first
    typedef struct packed {
        logic [1:0] cnt;
        frame_t     first;
        frame_t     second;
    } push_t;

endpackage

// ===== rtl/lcrs_ifs.sv =====
// Handshake interfaces for the tick input channel and the frame output channel.
interface lcrs_tick_if;
    logic valid;
    logic ready;
    logic active;

    modport source (output valid, output active, input ready);
    modport sink (input valid, input active, output ready);
endinterface

interface lcrs_frame_if;
    logic       valid;
    logic       ready;
    logic       fill_all;
    logic [1:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (output valid, output fill_all, output led_index, output red,
                    output green, output blue, output last, input ready);
    modport sink (input valid, input fill_all, input led_index, input red,
                  input green, input blue, input last, output ready);
endinterface

// ===== rtl/led_color_ramp_sequencer_top.sv =====
// Top level of the LED color ramp sequencer.
// Each accepted tick on the tick channel advances a waiting animation that walks
// every LED through a red, green and blue ramp; a tick that is due for a frame
// yields one frame item on the frame channel, and the tick that opens a pass
// yields two (a dim white fill of all LEDs, then the LED frame, which carries
// last). A tick with active low rewinds the animation and yields nothing. The
// first frame of a tick is offered in the cycle after the tick at the earliest.
// A tick is taken in a cycle when the three-entry output queue keeps at most one
// frame after the frame leaving in that cycle. With the frame channel always
// ready the block takes one tick per cycle, except that a pass-opening tick that
// finds two frames queued fills the queue and holds off the next tick, and a
// pass-opening tick puts both of its frames on the frame channel in turn.
// Registers at byte addresses 0, 4, 8, 12: dim_level, full_level, step_ticks,
// hold_ticks; write them only while no tick's frames are outstanding.
module led_color_ramp_sequencer_top
#(
    parameter int LED_COUNT = lcrs_pkg::LED_COUNT_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    lcrs_tick_if.sink                   tick,
    lcrs_frame_if.source                frame,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcrs_pkg::ADDR_W-1:0] paddr,
    input  logic [lcrs_pkg::DATA_W-1:0] pwdata,
    output logic [lcrs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    lcrs_pkg::cfg_t   cfg;
    lcrs_pkg::push_t  push;
    lcrs_pkg::frame_t head;
    logic             space;
    logic             accept;

    assign pready     = 1'b1;
    assign tick.ready = space;
    assign accept     = tick.valid && space;

    lcrs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lcrs_seq #(.LED_COUNT(LED_COUNT)) u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .active (tick.active),
        .cfg    (cfg),
        .push   (push)
    );

    lcrs_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_frame (head)
    );

    // Drive the frame payload from the queue head
    assign frame.fill_all  = head.fill_all;
    assign frame.led_index = head.led_index;
    assign frame.red       = head.red;
    assign frame.green     = head.green;
    assign frame.blue      = head.blue;
    assign frame.last      = head.last;

    // An inactive tick never produces a frame
    a_inactive_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !tick.active) |-> (push.cnt == 2'd0))
        else $error("inactive tick produced a frame");

    // A pair of frames is always fill first, then the LED frame with last
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |->
        (push.first.fill_all && !push.first.last && push.second.last
         && !push.second.fill_all))
        else $error("frame pair out of order");

    // After frames are pushed in one cycle, the frame channel is valid in the next
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |=> frame.valid)
        else $error("pushed frame not offered");

endmodule

// ===== rtl/lcrs_regs.sv =====
// Configuration register file behind the APB-style port.
module lcrs_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcrs_pkg::ADDR_W-1:0] paddr,
    input  logic [lcrs_pkg::DATA_W-1:0] pwdata,
    output logic [lcrs_pkg::DATA_W-1:0] prdata,
    output lcrs_pkg::cfg_t             cfg
);

    lcrs_pkg::cfg_t     cfg_reg;
    lcrs_pkg::cfg_t     cfg_next;
    lcrs_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx   = lcrs_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    // Update the addressed register on the access cycle
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                lcrs_pkg::REG_DIM:  cfg_next.dim_level  = pwdata[7:0];
                lcrs_pkg::REG_FULL: cfg_next.full_level = pwdata[7:0];
                lcrs_pkg::REG_STEP: cfg_next.step_ticks = pwdata[15:0];
                lcrs_pkg::REG_HOLD: cfg_next.hold_ticks = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_level  <= lcrs_pkg::DIM_RESET;
            cfg_reg.full_level <= lcrs_pkg::FULL_RESET;
            cfg_reg.step_ticks <= lcrs_pkg::STEP_RESET;
            cfg_reg.hold_ticks <= lcrs_pkg::HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register, zero extended
    always_comb
    begin
        case (idx)
            lcrs_pkg::REG_DIM:  prdata = lcrs_pkg::DATA_W'(cfg_reg.dim_level);
            lcrs_pkg::REG_FULL: prdata = lcrs_pkg::DATA_W'(cfg_reg.full_level);
            lcrs_pkg::REG_STEP: prdata = lcrs_pkg::DATA_W'(cfg_reg.step_ticks);
            lcrs_pkg::REG_HOLD: prdata = lcrs_pkg::DATA_W'(cfg_reg.hold_ticks);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lcrs_blend.sv =====
// Color of one ramp frame: per channel blend of two levels, divided by ten.
module lcrs_blend
(
    input  lcrs_pkg::color_t  color,
    input  lcrs_pkg::phase_t  phase,
    input  logic [3:0]        step,
    input  logic [7:0]        dim_level,
    input  logic [7:0]        full_level,
    output logic [2:0][7:0]   rgb
);

    logic [3:0] s;

    // Clamp the step to the ramp length
    assign s = (step > lcrs_pkg::RAMP_STEPS) ? lcrs_pkg::RAMP_STEPS : step;

    // Blend each channel: (a*(10-s) + b*s) / 10, divide as multiply by reciprocal
    always_comb
    begin
        logic [7:0]  base;
        logic [7:0]  top;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [11:0] sum;
        logic [24:0] prod;
        for (int ch = 0; ch < 3; ch++)
        begin
            base = (color == lcrs_pkg::color_t'(2'(ch))) ? dim_level : 8'd0;
            top  = (color == lcrs_pkg::color_t'(2'(ch))) ? full_level : 8'd0;
            case (phase)
                lcrs_pkg::PH_WHITE_TO_DIM: begin a = dim_level; b = base;      end
                lcrs_pkg::PH_DIM_TO_FULL:  begin a = base;      b = top;       end
                lcrs_pkg::PH_HOLD:         begin a = top;       b = top;       end
                lcrs_pkg::PH_FULL_TO_DIM:  begin a = top;       b = base;      end
                default:                   begin a = base;      b = dim_level; end
            endcase
            sum  = 12'(a) * 12'(lcrs_pkg::RAMP_STEPS - s) + 12'(b) * 12'(s);
            prod = 25'(sum) * 25'(lcrs_pkg::DIV10_MUL);
            rgb[ch] = 8'(prod >> lcrs_pkg::DIV10_SHIFT);
        end
    end

endmodule

// ===== rtl/lcrs_seq.sv =====
// Animation position and frame timing; builds the frames of each accepted tick.
module lcrs_seq
#(
    parameter int LED_COUNT = lcrs_pkg::LED_COUNT_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            active,
    input  lcrs_pkg::cfg_t  cfg,
    output lcrs_pkg::push_t push
);

    localparam int LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    logic [LedW-1:0]  led_reg;
    logic [LedW-1:0]  led_next;
    lcrs_pkg::color_t color_reg;
    lcrs_pkg::color_t color_next;
    lcrs_pkg::phase_t phase_reg;
    lcrs_pkg::phase_t phase_next;
    logic [3:0]       step_reg;
    logic [3:0]       step_next;
    logic [15:0]      wait_reg;
    logic [15:0]      wait_next;
    logic             started_reg;
    logic             started_next;

    logic             fire;
    logic [15:0]      delay;
    logic [2:0][7:0]  rgb;
    lcrs_pkg::frame_t led_frame;
    lcrs_pkg::frame_t fill_frame;

    assign fire  = active && (wait_reg == 16'd0);
    assign delay = (phase_reg == lcrs_pkg::PH_HOLD) ? cfg.hold_ticks : cfg.step_ticks;

    lcrs_blend u_blend
    (
        .color      (color_reg),
        .phase      (phase_reg),
        .step       (step_reg),
        .dim_level  (cfg.dim_level),
        .full_level (cfg.full_level),
        .rgb        (rgb)
    );

    // Advance position and wait counter on each accepted tick; an inactive tick rewinds
    always_comb
    begin
        led_next     = led_reg;
        color_next   = color_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        wait_next    = wait_reg;
        started_next = started_reg;
        if (accept)
        begin
            if (!active)
            begin
                led_next     = '0;
                color_next   = lcrs_pkg::COL_RED;
                phase_next   = lcrs_pkg::PH_WHITE_TO_DIM;
                step_next    = '0;
                wait_next    = '0;
                started_next = 1'b0;
            end
            else if (wait_reg != 16'd0)
            begin
                wait_next = wait_reg - 16'd1;
            end
            else
            begin
                started_next = 1'b1;
                wait_next    = (delay == 16'd0) ? 16'd0 : delay - 16'd1;
                step_next    = step_reg + 4'd1;
                if (phase_reg == lcrs_pkg::PH_HOLD || step_reg >= lcrs_pkg::RAMP_STEPS)
                begin
                    step_next = '0;
                    if (phase_reg == lcrs_pkg::PH_DIM_TO_WHITE)
                    begin
                        phase_next = lcrs_pkg::PH_WHITE_TO_DIM;
                        if (color_reg == lcrs_pkg::COL_BLUE)
                        begin
                            color_next = lcrs_pkg::COL_RED;
                            if (led_reg == LedW'(LED_COUNT - 1))
                            begin
                                led_next     = '0;
                                started_next = 1'b0;
                            end
                            else
                            begin
                                led_next = led_reg + LedW'(1);
                            end
                        end
                        else
                        begin
                            color_next = lcrs_pkg::color_t'(color_reg + 2'd1);
                        end
                    end
                    else
                    begin
                        phase_next = lcrs_pkg::phase_t'(phase_reg + 3'd1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg     <= '0;
            color_reg   <= lcrs_pkg::COL_RED;
            phase_reg   <= lcrs_pkg::PH_WHITE_TO_DIM;
            step_reg    <= '0;
            wait_reg    <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            led_reg     <= led_next;
            color_reg   <= color_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            wait_reg    <= wait_next;
            started_reg <= started_next;
        end
    end

    // Build the LED frame and the pass-opening fill frame
    always_comb
    begin
        led_frame.fill_all  = 1'b0;
        led_frame.led_index = 2'(led_reg);
        led_frame.red       = rgb[0];
        led_frame.green     = rgb[1];
        led_frame.blue      = rgb[2];
        led_frame.last      = 1'b1;

        fill_frame.fill_all  = 1'b1;
        fill_frame.led_index = 2'd0;
        fill_frame.red       = cfg.dim_level;
        fill_frame.green     = cfg.dim_level;
        fill_frame.blue      = cfg.dim_level;
        fill_frame.last      = 1'b0;
    end

    // Hand one or two frames to the output queue when an accepted tick is due
    always_comb
    begin
        push.cnt    = 2'd0;
        push.first  = started_reg ? led_frame : fill_frame;
        push.second = led_frame;
        if (accept && fire)
        begin
            push.cnt = started_reg ? 2'd1 : 2'd2;
        end
    end

endmodule

// ===== rtl/lcrs_outq.sv =====
// Three-entry output queue: takes up to two frames a cycle, sends one when the frame channel is ready.
module lcrs_outq
(
    input  logic             clk,
    input  logic             rst_n,
    input  lcrs_pkg::push_t  push,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output lcrs_pkg::frame_t out_frame
);

    lcrs_pkg::frame_t q_reg  [lcrs_pkg::QUEUE_DEPTH];
    lcrs_pkg::frame_t q_next [lcrs_pkg::QUEUE_DEPTH];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;
    logic [1:0]       base;

    assign out_valid = (count_reg != 2'd0);
    assign out_frame = q_reg[0];
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - {1'b0, pop};
    // Room for two frames once this cycle's frame has left
    assign space     = !base[1];

    // Shift out the head, then append the new frames behind the rest
    always_comb
    begin
        for (int i = 0; i < lcrs_pkg::QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        if (push.cnt != 2'd0)
        begin
            q_next[base] = push.first;
        end
        if (push.cnt == 2'd2)
        begin
            q_next[2'(base + 2'd1)] = push.second;
        end
        count_next = base + push.cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < lcrs_pkg::QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule
